>>> hw/rtl/multi_channel_periodic_timer_table_unit_macros.svh
// Assertion macros used by the timer table checker.
`ifndef MULTI_CHANNEL_PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH
`define MULTI_CHANNEL_PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH

// Checked only while out of reset.
`define MCTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MCTT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mctt_pkg.sv
package mctt_pkg;

  // Fixed field widths
  localparam int unsigned ID_W   = 4;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned ID_SLOTS = 16;

  // Parameter defaults
  localparam int unsigned NUM_TIMERS_DEF  = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SERVICE = 2'd1,
    OP_ADD     = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_ACTIVE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DEL,
    ST_RESP
  } ctrl_state_t;

  // One timer entry: reload value and time left
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] remaining;
  } timer_entry_t;

  // Order list ports
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] addr;
    logic [ID_W-1:0] data;
  } ord_wr_t;

  typedef struct packed {
    logic            re;
    logic [ID_W-1:0] addr;
  } ord_rd_t;

  // Timer memory ports
  typedef struct packed {
    logic         we;
    logic [ID_W-1:0] addr;
    timer_entry_t data;
  } tmr_wr_t;

  typedef struct packed {
    logic            re;
    logic [ID_W-1:0] addr;
  } tmr_rd_t;

endpackage

>>> hw/rtl/mctt_if.sv
// Input item channel
interface mctt_in_if import mctt_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               op;
  logic [ID_W-1:0]   timer_id;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] initial_remaining;

  modport source (output valid, op, timer_id, period, initial_remaining, input ready);
  modport sink   (input valid, op, timer_id, period, initial_remaining, output ready);
  modport mon    (input valid, ready, op, timer_id, period, initial_remaining);
endinterface

// Result channel
interface mctt_out_if import mctt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [ID_W-1:0] fired_id;
  status_t         status;
  logic            last;

  modport source (output valid, kind, fired_id, status, last, input ready);
  modport sink   (input valid, kind, fired_id, status, last, output ready);
  modport mon    (input valid, ready, kind, fired_id, status, last);
endinterface

// Configuration write channel
interface mctt_cfg_if import mctt_pkg::*; ();
  logic valid;
  logic ready;
  logic timer_enable;

  modport source (output valid, timer_enable, input ready);
  modport sink   (input valid, timer_enable, output ready);
  modport mon    (input valid, ready, timer_enable);
endinterface

>>> hw/rtl/multi_channel_periodic_timer_table_unit.sv
// Periodic timer table.
// in_ch carries one transaction per item: tick, service pass, add or delete.
// out_ch returns results; cfg_ch writes timer_enable (always ready).
// A tick returns nothing and leaves the block idle; the next item is taken at once.
// Add: the accepted item moves the block to ST_RESP, which loads the result once the output register is free.
// Delete: the order list is scanned one entry per cycle, then the status
// result follows; a delete of an inactive id skips the scan.
// Service: order-list read, timer read and update form a three-stage walk
// through the two memories, one timer per cycle while no stalled result
// halts it; an empty table returns its result without a walk. One fired id
// is held back so that the final result can carry last.
// One item is worked at a time; in_ch.ready is high only while idle.
// Results sit in an output register; while the receiver stalls the walk
// halts on the next fired timer and resumes when the register frees.
// Reset (rst_n low, synchronous) clears the count, the active flags, the
// enable and the output valid; the memories need no clearing pass.
module multi_channel_periodic_timer_table_unit import mctt_pkg::*; #(
  parameter int unsigned NUM_TIMERS  = NUM_TIMERS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mctt_in_if.sink   in_ch,
  mctt_out_if.source out_ch,
  mctt_cfg_if.sink  cfg_ch
);

  localparam int unsigned SLOTS  = (NUM_TIMERS < ID_SLOTS) ? NUM_TIMERS : ID_SLOTS;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned WIDE_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;
  localparam logic [ID_W:0]    SLOT_LIM = (ID_W + 1)'(SLOTS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

  ctrl_state_t state_r, state_nxt;

  logic                   enable_r;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_WIDTH-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SLOTS-1:0]       flag_r, flag_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic                   ord_v_r, ord_v_nxt;
  logic [ID_W-1:0]        ord_idx_r, ord_idx_nxt;
  logic                   tmr_v_r, tmr_v_nxt;
  logic [ID_W-1:0]        tmr_id_r, tmr_id_nxt;
  logic                   found_r, found_nxt;
  logic [ID_W-1:0]        item_id_r, item_id_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]        pend_id_r, pend_id_nxt;
  status_t                resp_r, resp_nxt;

  logic            out_v_r, out_v_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  status_t         out_status_r, out_status_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_load;

  ord_wr_t         ord_wr;
  ord_rd_t         ord_rd;
  logic [ID_W-1:0] ord_rdata;
  tmr_wr_t         tmr_wr;
  tmr_rd_t         tmr_rd;
  timer_entry_t    tmr_rdata;

  logic              in_acc;
  logic              out_free;
  logic              more;
  logic              fire;
  logic              stall;
  logic              walk_drained;
  logic              del_done;
  logic              id_ok;
  logic              id_flag;
  logic [WIDE_W-1:0] now_wide;
  logic [TIME_W-1:0] rem_left;

  // Memories
  mctt_order_mem #(.DEPTH(SLOTS)) u_order (
    .clk   (clk),
    .wr    (ord_wr),
    .rd    (ord_rd),
    .rdata (ord_rdata)
  );

  mctt_timer_mem #(.DEPTH(SLOTS)) u_timer (
    .clk   (clk),
    .wr    (tmr_wr),
    .rd    (tmr_rd),
    .rdata (tmr_rdata)
  );

  // Handshake and status terms
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_v_r || out_ch.ready;
  assign more         = (scan_r < count_r);
  assign now_wide     = WIDE_W'(now_r);
  assign fire         = !(now_wide < WIDE_W'(tmr_rdata.remaining));
  assign rem_left     = tmr_rdata.remaining - TIME_W'(now_wide);
  assign stall        = tmr_v_r && fire && pend_v_r && !out_free;
  assign walk_drained = !more && !ord_v_r && !tmr_v_r;
  assign del_done     = !more && !ord_v_r;
  assign id_ok        = ({1'b0, in_ch.timer_id} < SLOT_LIM);
  assign id_flag      = flag_r[in_ch.timer_id[IDX_W-1:0]];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.op)
            OP_SERVICE: state_nxt = (count_r == '0) ? ST_RESP : ST_WALK;
            OP_ADD:     state_nxt = ST_RESP;
            OP_DELETE:  state_nxt = (id_ok && id_flag) ? ST_DEL : ST_RESP;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_drained && out_free) state_nxt = ST_IDLE;
      end
      ST_DEL: begin
        if (del_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory accesses and result loads
  always_comb begin
    elapsed_nxt    = elapsed_r;
    now_nxt        = now_r;
    count_nxt      = count_r;
    flag_nxt       = flag_r;
    scan_nxt       = scan_r;
    ord_v_nxt      = ord_v_r;
    ord_idx_nxt    = ord_idx_r;
    tmr_v_nxt      = tmr_v_r;
    tmr_id_nxt     = tmr_id_r;
    found_nxt      = found_r;
    item_id_nxt    = item_id_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    resp_nxt       = resp_r;
    out_load       = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ord_wr         = '0;
    ord_rd         = '0;
    tmr_wr         = '0;
    tmr_rd         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.op)
            OP_TICK: begin
              if (enable_r) elapsed_nxt = elapsed_r + COUNT_WIDTH'(1);
            end
            OP_SERVICE: begin
              resp_nxt = STAT_OK;
              if (count_r != '0) begin
                now_nxt     = elapsed_r;
                elapsed_nxt = '0;
                scan_nxt    = '0;
                pend_v_nxt  = 1'b0;
              end
            end
            OP_ADD: begin
              if (!id_ok) begin
                resp_nxt = STAT_NOT_FOUND;
              end else if (id_flag || count_r >= CNT_FULL) begin
                resp_nxt = STAT_ACTIVE;
              end else begin
                resp_nxt                            = STAT_OK;
                ord_wr.we                           = 1'b1;
                ord_wr.addr                         = ID_W'(count_r);
                ord_wr.data                         = in_ch.timer_id;
                tmr_wr.we                           = 1'b1;
                tmr_wr.addr                         = in_ch.timer_id;
                tmr_wr.data.period                  = in_ch.period;
                tmr_wr.data.remaining               = in_ch.initial_remaining;
                flag_nxt[in_ch.timer_id[IDX_W-1:0]] = 1'b1;
                count_nxt                           = count_r + CNT_W'(1);
              end
            end
            default: begin
              // delete
              if (!(id_ok && id_flag)) begin
                resp_nxt = STAT_NOT_FOUND;
              end else begin
                flag_nxt[in_ch.timer_id[IDX_W-1:0]] = 1'b0;
                item_id_nxt                         = in_ch.timer_id;
                scan_nxt                            = '0;
                found_nxt                           = 1'b0;
              end
            end
          endcase
        end
      end

      ST_WALK: begin
        if (!stall) begin
          // stage 1: read the next id from the order list
          if (more) begin
            ord_rd.re   = 1'b1;
            ord_rd.addr = ID_W'(scan_r);
            scan_nxt    = scan_r + CNT_W'(1);
            ord_v_nxt   = 1'b1;
          end else begin
            ord_v_nxt = 1'b0;
          end
          // stage 2: read that timer; ids are unique, so no clash with stage 3
          if (ord_v_r) begin
            tmr_rd.re   = 1'b1;
            tmr_rd.addr = ord_rdata;
            tmr_v_nxt   = 1'b1;
            tmr_id_nxt  = ord_rdata;
          end else begin
            tmr_v_nxt = 1'b0;
          end
          // stage 3: count down or reload, write back
          if (tmr_v_r) begin
            tmr_wr.we          = 1'b1;
            tmr_wr.addr        = tmr_id_r;
            tmr_wr.data.period = tmr_rdata.period;
            tmr_wr.data.remaining = fire ? tmr_rdata.period : rem_left;
            if (fire) begin
              // release the held fired id, hold the new one
              if (pend_v_r) begin
                out_load       = 1'b1;
                out_kind_nxt   = 1'b1;
                out_id_nxt     = pend_id_r;
                out_status_nxt = STAT_OK;
                out_last_nxt   = 1'b0;
              end
              pend_v_nxt  = 1'b1;
              pend_id_nxt = tmr_id_r;
            end
          end
        end
        // closing result of the pass
        if (walk_drained && out_free) begin
          out_load       = 1'b1;
          out_kind_nxt   = pend_v_r;
          out_id_nxt     = pend_v_r ? pend_id_r : '0;
          out_status_nxt = STAT_OK;
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
        end
      end

      ST_DEL: begin
        // scan the order list, shift entries after the match down by one
        if (more) begin
          ord_rd.re   = 1'b1;
          ord_rd.addr = ID_W'(scan_r);
          scan_nxt    = scan_r + CNT_W'(1);
          ord_v_nxt   = 1'b1;
          ord_idx_nxt = ID_W'(scan_r);
        end else begin
          ord_v_nxt = 1'b0;
        end
        if (ord_v_r) begin
          if (found_r) begin
            ord_wr.we   = 1'b1;
            ord_wr.addr = ord_idx_r - ID_W'(1);
            ord_wr.data = ord_rdata;
          end else if (ord_rdata == item_id_r) begin
            found_nxt = 1'b1;
          end
        end
        if (del_done) begin
          count_nxt = count_r - CNT_W'(1);
          found_nxt = 1'b0;
          resp_nxt  = STAT_OK;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_kind_nxt   = 1'b0;
          out_id_nxt     = '0;
          out_status_nxt = resp_r;
          out_last_nxt   = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // Output register valid
  assign out_v_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      enable_r   <= 1'b0;
      elapsed_r  <= '0;
      count_r    <= '0;
      flag_r     <= '0;
      ord_v_r    <= 1'b0;
      tmr_v_r    <= 1'b0;
      found_r    <= 1'b0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_ch.valid) enable_r <= cfg_ch.timer_enable;
      elapsed_r  <= elapsed_nxt;
      count_r    <= count_nxt;
      flag_r     <= flag_nxt;
      ord_v_r    <= ord_v_nxt;
      tmr_v_r    <= tmr_v_nxt;
      found_r    <= found_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    scan_r       <= scan_nxt;
    ord_idx_r    <= ord_idx_nxt;
    tmr_id_r     <= tmr_id_nxt;
    item_id_r    <= item_id_nxt;
    pend_id_r    <= pend_id_nxt;
    resp_r       <= resp_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.fired_id = out_id_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

endmodule

>>> hw/rtl/mctt_order_mem.sv
// Insertion-order list of timer ids, one write and one registered read port
module mctt_order_mem import mctt_pkg::*; #(
  parameter int unsigned DEPTH = ID_SLOTS
) (
  input  logic            clk,
  input  ord_wr_t         wr,
  input  ord_rd_t         rd,
  output logic [ID_W-1:0] rdata
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
    // read data holds while no read is issued
    if (rd.re) begin
      rdata_r <= mem[rd.addr[IDX_W-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mctt_timer_mem.sv
// Per-id period and remaining time, one write and one registered read port
module mctt_timer_mem import mctt_pkg::*; #(
  parameter int unsigned DEPTH = ID_SLOTS
) (
  input  logic         clk,
  input  tmr_wr_t      wr,
  input  tmr_rd_t      rd,
  output timer_entry_t rdata
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  timer_entry_t mem [DEPTH];
  timer_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
    // read data holds while no read is issued
    if (rd.re) begin
      rdata_r <= mem[rd.addr[IDX_W-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mctt_checker.sv
`include "multi_channel_periodic_timer_table_unit_macros.svh"

// Port-level checks for the timer table
module mctt_checker import mctt_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input op_t             in_op,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_kind,
  input logic [ID_W-1:0] out_fired_id,
  input status_t         out_status
);

  logic tick_acc;
  logic out_stall;

  assign tick_acc  = in_valid && in_ready && (in_op == OP_TICK);
  assign out_stall = out_valid && !out_ready;

  // no result survives reset
  `MCTT_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  // status and empty-pass results carry no id
  `MCTT_ASSERT(a_status_no_id, out_valid && !out_kind |-> out_fired_id == '0, "id on status")

  // fired results always report ok
  `MCTT_ASSERT(a_fired_ok, out_valid && out_kind |-> out_status == STAT_OK, "fired not ok")

  // a tick transaction never makes the block busy
  `MCTT_ASSERT(a_tick_no_busy, tick_acc |=> in_ready, "busy after tick")

  // a stalled result holds its id
  `MCTT_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_fired_id), "result changed")

endmodule

bind multi_channel_periodic_timer_table_unit mctt_checker u_mctt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_op        (in_ch.op),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_fired_id (out_ch.fired_id),
  .out_status   (out_ch.status)
);

>>> sim/multi_channel_periodic_timer_table_unit_tb.sv
`timescale 1ns / 100ps

module multi_channel_periodic_timer_table_unit_tb;
  import mctt_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int TICK_RUN = 40;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] fired_id;
    status_t         status;
    logic            last;
  } timer_result_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   mismatches;

  mctt_in_if  in_ch();
  mctt_out_if out_ch();
  mctt_cfg_if cfg_ch();

  multi_channel_periodic_timer_table_unit #(
    .NUM_TIMERS (NUM_TIMERS_DEF),
    .COUNT_WIDTH(COUNT_WIDTH_DEF)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow copy of the timer table
  logic [COUNT_WIDTH_DEF-1:0] tick_count;
  logic [ID_W-1:0]            order_ids [ID_SLOTS];
  int                         n_active;
  logic                       is_active [ID_SLOTS];
  logic [TIME_W-1:0]          time_left [ID_SLOTS];
  logic [TIME_W-1:0]          reload    [ID_SLOTS];
  logic                       enable_shadow;

  timer_result_t pending_results[$];

  // Input pacing: gapless stretches and forced back-to-back bursts
  int gapless_left;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result-side backpressure: free-flowing stretches, short stalls, rare long stalls
  initial begin
    int r;
    int stall_len;
    int run_len;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        stall_len = 0;
        run_len = $urandom_range(10, 60);
      end else if (r < 92) begin
        stall_len = $urandom_range(1, 3);
        run_len = $urandom_range(1, 4);
      end else begin
        stall_len = $urandom_range(10, 30);
        run_len = $urandom_range(1, 4);
      end
      repeat (stall_len) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      repeat (run_len) begin
        @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // Predict the results of one accepted item and update the shadow table
  task automatic predict_timer_table(op_t op, logic [ID_W-1:0] id,
                                     logic [TIME_W-1:0] per, logic [TIME_W-1:0] init);
    timer_result_t r;
    logic [COUNT_WIDTH_DEF-1:0] now;
    logic [ID_W-1:0] fired[$];
    logic [ID_W-1:0] t;
    int slot;
    r = '{kind: 1'b0, fired_id: '0, status: STAT_OK, last: 1'b1};
    case (op)
      OP_TICK: begin
        if (enable_shadow) tick_count = tick_count + 1'b1;
      end
      OP_SERVICE: begin
        if (n_active == 0) begin
          pending_results.push_back(r);
        end else begin
          now = tick_count;
          tick_count = '0;
          for (int i = 0; i < n_active; i++) begin
            t = order_ids[i];
            if (COUNT_WIDTH_DEF'(now) < time_left[t]) begin
              time_left[t] = time_left[t] - TIME_W'(now);
            end else begin
              time_left[t] = reload[t];
              fired.push_back(t);
            end
          end
          if (fired.size() == 0) begin
            pending_results.push_back(r);
          end else begin
            foreach (fired[k]) begin
              r.kind = 1'b1;
              r.fired_id = fired[k];
              r.last = (k == fired.size() - 1);
              pending_results.push_back(r);
            end
          end
        end
      end
      OP_ADD: begin
        if (int'(id) >= NUM_TIMERS_DEF) begin
          r.status = STAT_NOT_FOUND;
        end else if (is_active[id] || n_active >= ID_SLOTS) begin
          r.status = STAT_ACTIVE;
        end else begin
          order_ids[n_active] = id;
          n_active++;
          is_active[id] = 1'b1;
          time_left[id] = init;
          reload[id] = per;
        end
        pending_results.push_back(r);
      end
      default: begin
        if (int'(id) >= NUM_TIMERS_DEF || !is_active[id]) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          slot = -1;
          for (int i = 0; i < n_active; i++) begin
            if (slot < 0 && order_ids[i] == id) slot = i;
          end
          for (int j = slot; j + 1 < n_active; j++) order_ids[j] = order_ids[j + 1];
          n_active--;
          is_active[id] = 1'b0;
        end
        pending_results.push_back(r);
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (gapless_left > 0) begin
      gapless_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      gapless_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Send one item; returns at the edge where the transaction is accepted
  task automatic send_item(op_t op, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] per, logic [TIME_W-1:0] init);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.timer_id = id;
    in_ch.period = per;
    in_ch.initial_remaining = init;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_timer_table(op, id, per, init);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_idle(int settle);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_enable(logic en);
    wait_idle(SETTLE_CYCLES);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.timer_enable = en;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    enable_shadow = en;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d id %0d status %0d last %0d",
                   out_ch.kind, out_ch.fired_id, out_ch.status, out_ch.last);
        mismatches++;
      end else begin
        if (out_ch.kind !== pending_results[0].kind ||
            out_ch.fired_id !== pending_results[0].fired_id ||
            out_ch.status !== pending_results[0].status ||
            out_ch.last !== pending_results[0].last) begin
          if (mismatches < 10)
            $display({"mismatch: expected kind %0d id %0d status %0d last %0d,",
                      " got %0d %0d %0d %0d"},
                     pending_results[0].kind, pending_results[0].fired_id,
                     pending_results[0].status, pending_results[0].last,
                     out_ch.kind, out_ch.fired_id, out_ch.status, out_ch.last);
          mismatches++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Fresh out of reset: empty pass, delete miss, ticks ignored while disabled
  task automatic test_reset_behavior();
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
    send_item(OP_DELETE, 4'd4, 16'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 16'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 16'd0, 16'd0);
    write_enable(1'b1);
    send_item(OP_ADD, 4'd2, 16'd5, 16'd2);
    // count still zero, so timer 2 must not fire
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
  endtask

  // Add and delete status codes, field extremes
  task automatic test_add_delete();
    send_item(OP_ADD, 4'd2, 16'd1, 16'd1);
    send_item(OP_ADD, 4'd15, 16'hFFFF, 16'hFFFF);
    send_item(OP_ADD, 4'd0, 16'd0, 16'd0);
    send_item(OP_DELETE, 4'd9, 16'hFFFF, 16'hFFFF);
    send_item(OP_DELETE, 4'd2, 16'd0, 16'd0);
    send_item(OP_DELETE, 4'd2, 16'd0, 16'd0);
  endtask

  // Service passes: fire, zero period, no fire, empty table keeps the count
  task automatic test_service_passes();
    repeat (3) send_item(OP_TICK, 4'd0, 16'd0, 16'd0);
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
    send_item(OP_DELETE, 4'd0, 16'd0, 16'd0);
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 16'd0, 16'd0);
    send_item(OP_DELETE, 4'd15, 16'd0, 16'd0);
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
    send_item(OP_ADD, 4'd5, 16'hFFFF, 16'd1);
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
  endtask

  // Back-to-back tick run: one timer, a long count taken by one pass
  task automatic test_tick_run();
    logic [ID_W-1:0] victims[$];
    for (int i = 0; i < n_active; i++) victims.push_back(order_ids[i]);
    foreach (victims[k]) send_item(OP_DELETE, victims[k], 16'd0, 16'd0);
    send_item(OP_ADD, 4'd3, 16'd9, 16'd5);
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
    no_gaps = 1'b1;
    repeat (TICK_RUN) send_item(OP_TICK, 4'd0, 16'd0, 16'd0);
    no_gaps = 1'b0;
    send_item(OP_SERVICE, 4'd0, 16'd0, 16'd0);
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return TIME_W'($urandom_range(0, 12));
    if (r < 85) return TIME_W'($urandom);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return TIME_W'(1);
      default: return TIME_W'(16'hFFFE);
    endcase
  endfunction

  // Random traffic; mostly legal adds/deletes, some duplicates and misses
  task automatic test_random_traffic(int n_items, int add_pct, int del_pct, int svc_pct);
    int r;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] free_ids[$];
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      id = ID_W'($urandom);
      if (r < add_pct) begin
        free_ids.delete();
        for (int i = 0; i < ID_SLOTS; i++) if (!is_active[i]) free_ids.push_back(ID_W'(i));
        if (free_ids.size() != 0 && $urandom_range(0, 99) < 80)
          id = free_ids[$urandom_range(0, free_ids.size() - 1)];
        send_item(OP_ADD, id, pick_time(), pick_time());
      end else if (r < add_pct + del_pct) begin
        if (n_active != 0 && $urandom_range(0, 99) < 75)
          id = order_ids[$urandom_range(0, n_active - 1)];
        send_item(OP_DELETE, id, TIME_W'($urandom), TIME_W'($urandom));
      end else if (r < add_pct + del_pct + svc_pct) begin
        send_item(OP_SERVICE, id, TIME_W'($urandom), TIME_W'($urandom));
      end else begin
        send_item(OP_TICK, id, TIME_W'($urandom), TIME_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_TICK;
    in_ch.timer_id = '0;
    in_ch.period = '0;
    in_ch.initial_remaining = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.timer_enable = 1'b0;
    mismatches = 0;
    tick_count = '0;
    n_active = 0;
    enable_shadow = 1'b0;
    gapless_left = 0;
    no_gaps = 1'b0;
    for (int i = 0; i < ID_SLOTS; i++) begin
      order_ids[i] = '0;
      is_active[i] = 1'b0;
      time_left[i] = '0;
      reload[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_behavior();
    test_add_delete();
    test_service_passes();
    test_tick_run();

    // Random phases across enable settings
    test_random_traffic(90, 45, 10, 15);
    write_enable(1'b0);
    test_random_traffic(50, 25, 20, 25);
    write_enable(1'b1);
    test_random_traffic(110, 20, 20, 20);
    write_enable(1'b0);
    write_enable(1'b1);
    test_random_traffic(90, 40, 10, 20);

    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mctt_pkg.sv
hw/rtl/mctt_if.sv
hw/rtl/mctt_order_mem.sv
hw/rtl/mctt_timer_mem.sv
hw/rtl/multi_channel_periodic_timer_table_unit.sv
hw/rtl/mctt_checker.sv
sim/multi_channel_periodic_timer_table_unit_tb.sv
